>>> design/accel_fall_detector_top_macros.svh
// assertion macros for the fall detector
`ifndef ACCEL_FALL_DETECTOR_TOP_MACROS_SVH
`define ACCEL_FALL_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AFD_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define AFD_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define AFD_ASSERT_IMPL(label, clk, rst, prop)
`define AFD_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> design/afd_pkg.sv
package afd_pkg;
   localparam int AdcW = 10;
   localparam int TimeW = 32;
   localparam int MagW = 15;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0, EV_POSSIBLE = 3'd1, EV_CANCEL = 3'd2,
      EV_CONFIRM = 3'd3, EV_TIMEOUT = 3'd4, EV_REARM = 3'd5
   } event_type;

   localparam logic [2:0] CSR_BASE_X = 3'd0;
   localparam logic [2:0] CSR_BASE_Y = 3'd1;
   localparam logic [2:0] CSR_BASE_Z = 3'd2;
   localparam logic [2:0] CSR_IMPACT = 3'd3;
   localparam logic [2:0] CSR_STILL = 3'd4;
   localparam logic [2:0] CSR_CANCEL = 3'd5;
   localparam logic [2:0] CSR_CONFIRM = 3'd6;
   localparam logic [2:0] CSR_COOLDOWN = 3'd7;

   typedef struct packed {
      logic [9:0]  accel_x;
      logic [9:0]  accel_y;
      logic [9:0]  accel_z;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic        led;
      logic        fall_flag;
      logic        in_possible_fall;
      logic [1:0]  buzz_count;
      logic [14:0] magnitude;
   } rsp_type;

   // front to back queue entry
   typedef struct packed {
      logic [9:0]  accel_z;
      logic [31:0] now_ms;
      logic [14:0] magnitude;
   } mag_type;
endpackage

>>> design/afd_front.sv
// front: deviation squares and a bit-serial square root
module afd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  afd_pkg::req_type    in_word,
   input  logic [13:0]         base_x,
   input  logic [13:0]         base_y,
   input  logic [13:0]         base_z,
   output logic                out_valid,
   input  logic                out_ready,
   output afd_pkg::mag_type    out_word
);
   import afd_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_DONE} fstate_type;

   fstate_type  state_ff, state_in;
   logic [13:0] dx_ff, dy_ff, dz_ff;
   logic [29:0] acc_ff, acc_in;
   logic [30:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  sq_ff, sq_in;
   logic [9:0]  z_ff;
   logic [31:0] t_ff;
   logic [13:0] sel;
   logic [27:0] prod;
   logic [13:0] ax, ay, az;
   logic [31:0] trial;
   logic [31:0] rem_sh;

   function automatic logic [13:0] adiff(input logic [13:0] a, input logic [13:0] b);
      adiff = (a > b) ? a - b : b - a;
   endfunction

   assign ax = {in_word.accel_x, 4'b0};
   assign ay = {in_word.accel_y, 4'b0};
   assign az = {in_word.accel_z, 4'b0};

   always_comb begin
      case (sq_ff)
         2'd0: sel = dx_ff;
         2'd1: sel = dy_ff;
         default: sel = dz_ff;
      endcase
   end
   assign prod = sel * sel;

   // one root bit per cycle: remainder shifted two bits in
   assign rem_sh = {rem_ff[29:0], acc_ff[29:28]};
   assign trial  = {14'b0, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      sq_in = sq_ff;
      case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               state_in = F_SQ;
               acc_in = '0;
               sq_in = 2'd0;
            end
         end
         F_SQ: begin
            acc_in = acc_ff + {2'b0, prod};
            sq_in = sq_ff + 2'd1;
            if (sq_ff == 2'd2) begin
               state_in = F_ROOT;
               rem_in = '0;
               root_in = '0;
               // 15 bit pairs in the 30-bit sum
               cnt_in = 5'd14;
            end
         end
         F_ROOT: begin
            acc_in = {acc_ff[27:0], 2'b0};
            if (rem_sh >= trial) begin
               rem_in = 31'(rem_sh - trial);
               root_in = {root_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh[30:0];
               root_in = {root_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = F_DONE;
         end
         F_DONE: begin
            if (out_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      sq_ff <= sq_in;
      if (state_ff == F_IDLE && in_valid) begin
         dx_ff <= adiff(ax, base_x);
         dy_ff <= adiff(ay, base_y);
         dz_ff <= adiff(az, base_z);
         z_ff <= in_word.accel_z;
         t_ff <= in_word.now_ms;
      end
   end

   assign in_ready = (state_ff == F_IDLE);
   assign out_valid = (state_ff == F_DONE);
   assign out_word.accel_z = z_ff;
   assign out_word.now_ms = t_ff;
   assign out_word.magnitude = root_ff[15] ? 15'h7FFF : root_ff[14:0];
endmodule

>>> design/afd_back.sv
// back: fall state machine, one magnitude word at a time
module afd_back #(
   parameter int IMPACT_SAMPLES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  afd_pkg::mag_type  in_word,
   input  logic [14:0]       impact_level,
   input  logic [14:0]       still_level,
   input  logic [14:0]       cancel_level,
   input  logic [15:0]       confirm_ms,
   input  logic [15:0]       cooldown_ms,
   output logic              out_valid,
   input  logic              out_ready,
   output afd_pkg::rsp_type  out_word
);
   import afd_pkg::*;

   localparam logic [31:0] ZLimit = 32'd400;
   localparam logic [31:0] SettleMs = 32'd3000;
   localparam logic [31:0] WindowMs = 32'd5000;
   localparam logic [31:0] TimeoutMs = 32'd30000;
   localparam logic [31:0] BlinkMs = 32'd1000;
   localparam logic [12:0] MaxCnt = 13'd4096;

   typedef enum logic [2:0] {B_IDLE, B_A, B_MUL1, B_MUL2, B_B, B_OUT} bstate_type;

   bstate_type  state_ff;
   logic        possible_ff, latch_ff, armed_ff, wopen_ff, sopen_ff, blink_ff;
   logic [1:0]  run_ff;
   logic [31:0] fstart_ff, lend_ff, wstart_ff, sstart_ff, btime_ff;
   logic [14:0] prev_ff;
   logic [26:0] sum_ff;
   logic [12:0] cnt_ff;
   mag_type     w_ff;
   logic [2:0]  ev_ff;
   logic [1:0]  buzz_ff;
   logic        led_ff;
   logic [27:0] cprod_ff, sprod_ff;
   logic        wend_ff;
   rsp_type     rsp_ff;

   logic [31:0] now;
   logic [14:0] mag;
   logic [14:0] dmag;
   logic        cool, impact;
   logic [1:0]  run_n;

   assign now = w_ff.now_ms;
   assign mag = w_ff.magnitude;
   assign dmag = (mag > prev_ff) ? mag - prev_ff : prev_ff - mag;
   assign cool = (now - lend_ff) < {16'b0, cooldown_ms};
   assign impact = (mag > impact_level) && ({22'b0, w_ff.accel_z} < ZLimit);

   always_comb begin
      if (cool) run_n = 2'd0;
      else if (impact && (armed_ff || (!armed_ff && !cool)))
         run_n = (run_ff == 2'd3) ? 2'd3 : run_ff + 2'd1;
      else run_n = 2'd0;
      // re-arm clears the run before counting
      if (!armed_ff && !cool) run_n = impact ? 2'd1 : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         possible_ff <= 1'b0; latch_ff <= 1'b0; armed_ff <= 1'b1;
         wopen_ff <= 1'b0; sopen_ff <= 1'b0; blink_ff <= 1'b0;
         run_ff <= '0; fstart_ff <= '0; lend_ff <= '0; wstart_ff <= '0;
         sstart_ff <= '0; btime_ff <= '0; prev_ff <= '0; sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (in_valid) begin
                  w_ff <= in_word;
                  state_ff <= B_A;
               end
            end
            B_A: begin
               ev_ff <= EV_NONE;
               buzz_ff <= 2'd0;
               state_ff <= B_B;
               if (!possible_ff) begin
                  led_ff <= latch_ff;
                  if (!armed_ff && !cool) begin
                     armed_ff <= 1'b1;
                     ev_ff <= EV_REARM;
                  end
                  if (run_n >= 2'(IMPACT_SAMPLES)) begin
                     possible_ff <= 1'b1;
                     fstart_ff <= now;
                     sopen_ff <= 1'b0; sstart_ff <= '0;
                     sum_ff <= '0; cnt_ff <= '0;
                     wopen_ff <= 1'b0; wstart_ff <= '0;
                     prev_ff <= mag;
                     btime_ff <= now;
                     blink_ff <= 1'b0;
                     run_ff <= '0;
                     armed_ff <= 1'b0;
                     ev_ff <= EV_POSSIBLE;
                     buzz_ff <= 2'd1;
                     led_ff <= 1'b0;
                     state_ff <= B_OUT;
                  end else begin
                     run_ff <= run_n;
                     state_ff <= B_OUT;
                  end
               end
            end
            B_B: begin
               // possible fall: blink, settle, accumulate
               if (now - btime_ff >= BlinkMs) begin
                  blink_ff <= ~blink_ff;
                  btime_ff <= now;
               end
               if (now - fstart_ff < SettleMs) begin
                  led_ff <= (now - btime_ff >= BlinkMs) ? ~blink_ff : blink_ff;
                  state_ff <= B_OUT;
               end else begin
                  if (!wopen_ff) begin
                     wopen_ff <= 1'b1;
                     wstart_ff <= now;
                     if (cnt_ff < MaxCnt) begin
                        sum_ff <= sum_ff;
                        cnt_ff <= cnt_ff + 13'd1;
                     end
                     wend_ff <= 1'b0;
                  end else begin
                     if (cnt_ff < MaxCnt) begin
                        sum_ff <= sum_ff + {12'b0, dmag};
                        cnt_ff <= cnt_ff + 13'd1;
                     end
                     wend_ff <= (now - wstart_ff) >= WindowMs;
                  end
                  prev_ff <= mag;
                  state_ff <= B_MUL1;
               end
            end
            B_MUL1: begin
               cprod_ff <= cancel_level * cnt_ff;
               sprod_ff <= still_level * cnt_ff;
               state_ff <= B_MUL2;
            end
            B_MUL2: begin
               state_ff <= B_OUT;
               if (wend_ff) begin
                  sum_ff <= '0; cnt_ff <= '0; wstart_ff <= now;
                  if (cnt_ff != 13'd0 && {1'b0, sum_ff} >= cprod_ff) begin
                     possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                     wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                     run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                     lend_ff <= now; armed_ff <= 1'b0;
                     ev_ff <= EV_CANCEL; led_ff <= 1'b0;
                  end else if (cnt_ff != 13'd0 && {1'b0, sum_ff} < sprod_ff) begin
                     if (!sopen_ff) begin
                        sopen_ff <= 1'b1; sstart_ff <= now;
                        if (now - fstart_ff > TimeoutMs) begin
                           possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                           wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                           run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                           lend_ff <= now; armed_ff <= 1'b0;
                           ev_ff <= EV_TIMEOUT; led_ff <= 1'b0;
                        end else led_ff <= blink_ff | latch_ff;
                     end else if (now - sstart_ff >= {16'b0, confirm_ms}) begin
                        latch_ff <= 1'b1;
                        possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                        wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                        run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                        lend_ff <= now; armed_ff <= 1'b1;
                        ev_ff <= EV_CONFIRM; buzz_ff <= 2'd3; led_ff <= 1'b0;
                     end else if (now - fstart_ff > TimeoutMs) begin
                        possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                        wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                        run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                        lend_ff <= now; armed_ff <= 1'b0;
                        ev_ff <= EV_TIMEOUT; led_ff <= 1'b0;
                     end else led_ff <= blink_ff | latch_ff;
                  end else begin
                     if (now - fstart_ff > TimeoutMs) begin
                        possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                        wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                        run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                        lend_ff <= now; armed_ff <= 1'b0;
                        ev_ff <= EV_TIMEOUT; led_ff <= 1'b0;
                     end else begin
                        sopen_ff <= 1'b0; sstart_ff <= '0;
                        led_ff <= blink_ff | latch_ff;
                     end
                  end
               end else if (now - fstart_ff > TimeoutMs) begin
                  possible_ff <= 1'b0; sopen_ff <= 1'b0; sstart_ff <= '0;
                  sum_ff <= '0; cnt_ff <= '0;
                  wopen_ff <= 1'b0; wstart_ff <= '0; prev_ff <= '0;
                  run_ff <= '0; fstart_ff <= '0; blink_ff <= 1'b0;
                  lend_ff <= now; armed_ff <= 1'b0;
                  ev_ff <= EV_TIMEOUT; led_ff <= 1'b0;
               end else begin
                  led_ff <= blink_ff | latch_ff;
               end
            end
            B_OUT: begin
               if (!out_valid || out_ready) begin
                  rsp_ff.event_res <= ev_ff;
                  rsp_ff.led <= led_ff;
                  rsp_ff.fall_flag <= latch_ff;
                  rsp_ff.in_possible_fall <= possible_ff;
                  rsp_ff.buzz_count <= buzz_ff;
                  rsp_ff.magnitude <= mag;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // result holding register
   logic ovalid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (state_ff == B_OUT && (!ovalid_ff || out_ready)) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_word = rsp_ff;
   assign in_ready = (state_ff == B_IDLE);
endmodule

>>> design/afd_queue.sv
// two-entry word queue between front and back
module afd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  afd_pkg::mag_type in_word,
   output logic             out_valid,
   input  logic             out_ready,
   output afd_pkg::mag_type out_word
);
   import afd_pkg::*;

   mag_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_word;
   end
endmodule

>>> design/accel_fall_detector_top.sv
// Fall detector over 3-axis accelerometer words. A front unit takes each
// sample, forms per-axis deviation from the baseline and a bit-serial
// square root; it works on one word at a time (accept, the square-and-add
// steps for the three axes, the root steps, hand-off). A two-word queue feeds
// the back unit, which runs the impact / settle / window / confirm logic with
// one registered multiply stage. One result word per sample comes out in order.
// The front takes a new sample only after it has handed off the last one, so
// the square root loop sets the throughput.
// IMPACT_SAMPLES (1 to 3) is how many impact samples in a row start a
// possible fall. Configure only while idle.
`include "accel_fall_detector_top_macros.svh"
module accel_fall_detector_top #(
   parameter int IMPACT_SAMPLES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  afd_pkg::req_type  req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output afd_pkg::rsp_type  rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import afd_pkg::*;

   // configuration registers
   logic [13:0] base_x_ff, base_y_ff, base_z_ff;
   logic [14:0] impact_ff, still_ff, cancel_ff;
   logic [15:0] confirm_ff, cooldown_ff;

   logic    f_valid, f_ready, b_valid, b_ready, out_valid;
   mag_type f_word, b_word;
   logic    front_ready;

   // result word carries a buzz request / event that may buzz
   logic    rsp_buzz, rsp_buzz_event;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= 14'd8184; base_y_ff <= 14'd8184; base_z_ff <= 14'd8184;
         impact_ff <= 15'd2080; still_ff <= 15'd112; cancel_ff <= 15'd1280;
         confirm_ff <= 16'd10000; cooldown_ff <= 16'd6000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_X:   base_x_ff <= csr_data[13:0];
            CSR_BASE_Y:   base_y_ff <= csr_data[13:0];
            CSR_BASE_Z:   base_z_ff <= csr_data[13:0];
            CSR_IMPACT:   impact_ff <= csr_data[14:0];
            CSR_STILL:    still_ff <= csr_data[14:0];
            CSR_CANCEL:   cancel_ff <= csr_data[14:0];
            CSR_CONFIRM:  confirm_ff <= csr_data;
            CSR_COOLDOWN: cooldown_ff <= csr_data;
            default: ;
         endcase
      end
   end

   afd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_push), .in_ready(front_ready), .in_word(req_word),
      .base_x(base_x_ff), .base_y(base_y_ff), .base_z(base_z_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
   );
   assign req_full = !front_ready;

   afd_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
      .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
   );

   afd_back #(.IMPACT_SAMPLES(IMPACT_SAMPLES)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready), .in_word(b_word),
      .impact_level(impact_ff), .still_level(still_ff),
      .cancel_level(cancel_ff), .confirm_ms(confirm_ff),
      .cooldown_ms(cooldown_ff),
      .out_valid(out_valid), .out_ready(rsp_pop), .out_word(rsp_word)
   );
   assign rsp_empty = !out_valid;

   assign rsp_buzz = !rsp_empty && (rsp_word.buzz_count != 2'd0);
   assign rsp_buzz_event = (rsp_word.event_res == EV_POSSIBLE) ||
                           (rsp_word.event_res == EV_CONFIRM);

   // a result word holds while it waits
   `AFD_ASSERT_IMPL(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> $stable(rsp_word))
   // buzz only with a possible fall or confirm
   `AFD_ASSERT_IMPL(a_buzz, clock, reset, rsp_buzz |-> rsp_buzz_event)
   // empty after reset
   `AFD_ASSERT_NORST(a_reset_empty, clock, reset |=> rsp_empty)
endmodule

>>> tb/tb_accel_fall_detector_top.sv
module tb_accel_fall_detector_top;
   timeunit 1ns;
   timeprecision 1ps;

   import afd_pkg::*;

   localparam int IMPACT_N = 3;
   localparam int TOTAL_WORDS = 1450;

   // scoreboard: holds its own copy of the detector state and the register
   // file, predicts one result word per accepted sample and checks results
   class fall_scoreboard;
      // register file
      bit [13:0] base_x, base_y, base_z;
      bit [14:0] impact_lvl, still_lvl, cancel_lvl;
      bit [15:0] confirm_span, cooldown_time;
      // detector state
      bit        possible, latched, armed, win_open, still_on, blink;
      bit [1:0]  impact_cnt;
      bit [31:0] fall_t0, end_t, win_t0, still_t0, blink_t;
      longint unsigned last_mag, change_sum, change_cnt;
      // bookkeeping
      rsp_type   expected_words[$];
      int        words_in, words_out, mismatches;
      int        event_seen[6];

      function new();
         base_x = 14'd8184;
         base_y = 14'd8184;
         base_z = 14'd8184;
         impact_lvl = 15'd2080;
         still_lvl = 15'd112;
         cancel_lvl = 15'd1280;
         confirm_span = 16'd10000;
         cooldown_time = 16'd6000;
         possible = 0;
         latched = 0;
         armed = 1;
         win_open = 0;
         still_on = 0;
         blink = 0;
         impact_cnt = 0;
         fall_t0 = 0;
         end_t = 0;
         win_t0 = 0;
         still_t0 = 0;
         blink_t = 0;
         last_mag = 0;
         change_sum = 0;
         change_cnt = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_BASE_X:   base_x = val[13:0];
            CSR_BASE_Y:   base_y = val[13:0];
            CSR_BASE_Z:   base_z = val[13:0];
            CSR_IMPACT:   impact_lvl = val[14:0];
            CSR_STILL:    still_lvl = val[14:0];
            CSR_CANCEL:   cancel_lvl = val[14:0];
            CSR_CONFIRM:  confirm_span = val;
            CSR_COOLDOWN: cooldown_time = val;
            default: ;
         endcase
      endfunction

      static function longint unsigned gap(longint unsigned a, longint unsigned b);
         return (a > b) ? a - b : b - a;
      endfunction

      // floor square root, two bits of the radicand per pass
      static function longint unsigned floor_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function void close_alarm(bit [31:0] now, bit rearm);
         possible = 0;
         still_on = 0;
         still_t0 = 0;
         change_sum = 0;
         change_cnt = 0;
         win_open = 0;
         win_t0 = 0;
         last_mag = 0;
         impact_cnt = 0;
         fall_t0 = 0;
         blink = 0;
         end_t = now;
         armed = rearm;
      endfunction

      // one sample in, one result word out
      function rsp_type detect_fall(req_type s);
         longint unsigned dx, dy, dz, mag, tot, cnt;
         bit [31:0] now;
         bit        cool, hit, done, led;
         event_type ev;
         bit [1:0]  buzz;
         rsp_type   w;
         now = s.now_ms;
         dx = gap(longint'(s.accel_x) << 4, base_x);
         dy = gap(longint'(s.accel_y) << 4, base_y);
         dz = gap(longint'(s.accel_z) << 4, base_z);
         mag = floor_root(dx * dx + dy * dy + dz * dz);
         if (mag > 32767) mag = 32767;
         ev = EV_NONE;
         buzz = 0;
         led = 0;
         done = 0;

         if (!possible) begin
            cool = (32'(now - end_t) < cooldown_time);
            hit = (mag > impact_lvl) && (s.accel_z < 400);
            if (!armed && !cool) begin
               armed = 1;
               impact_cnt = 0;
               ev = EV_REARM;
            end
            if (cool) impact_cnt = 0;
            else if (hit && armed) begin
               if (impact_cnt < 3) impact_cnt++;
            end else impact_cnt = 0;
            if (impact_cnt >= IMPACT_N) begin
               possible = 1;
               fall_t0 = now;
               still_on = 0;
               still_t0 = 0;
               change_sum = 0;
               change_cnt = 0;
               win_open = 0;
               win_t0 = 0;
               last_mag = mag;
               blink_t = now;
               blink = 0;
               impact_cnt = 0;
               armed = 0;
               ev = EV_POSSIBLE;
               buzz = 1;
            end
         end

         if (possible) begin
            if (32'(now - blink_t) >= 1000) begin
               blink = !blink;
               blink_t = now;
            end
            // settling: just blink
            if (32'(now - fall_t0) < 3000) begin
               led = blink;
               done = 1;
            end
            if (!done) begin
               if (!win_open) begin
                  win_open = 1;
                  win_t0 = now;
                  last_mag = mag;
               end
               // a full window stops summing but keeps tracking the magnitude
               if (change_cnt < 4096) begin
                  change_sum += gap(mag, last_mag);
                  change_cnt++;
               end
               last_mag = mag;
               if (32'(now - win_t0) >= 5000) begin
                  tot = change_sum;
                  cnt = change_cnt;
                  change_sum = 0;
                  change_cnt = 0;
                  win_t0 = now;
                  if (cnt != 0 && tot >= cancel_lvl * cnt) begin
                     close_alarm(now, 0);
                     ev = EV_CANCEL;
                     done = 1;
                  end else if (cnt != 0 && tot < still_lvl * cnt) begin
                     if (!still_on) begin
                        still_on = 1;
                        still_t0 = now;
                     end else if (32'(now - still_t0) >= confirm_span) begin
                        latched = 1;
                        close_alarm(now, 1);
                        ev = EV_CONFIRM;
                        buzz = 3;
                        done = 1;
                     end
                  end else begin
                     still_on = 0;
                     still_t0 = 0;
                  end
               end
            end
            if (!done && 32'(now - fall_t0) > 30000) begin
               close_alarm(now, 0);
               ev = EV_TIMEOUT;
               done = 1;
            end
            if (!done) led = blink || latched;
         end else begin
            led = latched;
         end

         w.event_res = ev;
         w.led = led;
         w.fall_flag = latched;
         w.in_possible_fall = possible;
         w.buzz_count = buzz;
         w.magnitude = mag[14:0];
         return w;
      endfunction

      function void note_sample(req_type s);
         expected_words.push_back(detect_fall(s));
         words_in++;
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp_w;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         exp_w = expected_words.pop_front();
         words_out++;
         if (exp_w.event_res <= 5) event_seen[exp_w.event_res]++;
         if (got.event_res !== exp_w.event_res || got.led !== exp_w.led ||
             got.fall_flag !== exp_w.fall_flag ||
             got.in_possible_fall !== exp_w.in_possible_fall ||
             got.buzz_count !== exp_w.buzz_count ||
             got.magnitude !== exp_w.magnitude) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word %0d mismatch: expected %p, got %p", words_out, exp_w, got);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_word;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_word;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   fall_scoreboard fall_sb;
   bit        idle_on;        // random idle bursts on both sides
   bit [31:0] t_ms;           // stimulus timeline
   int        sent;
   bit [15:0] reg_val[8];     // current register settings seen by the stimulus

   accel_fall_detector_top #(.IMPACT_SAMPLES(IMPACT_N)) i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // monitor: both handshakes sampled at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) fall_sb.note_sample(req_word);
         if (rsp_pop && !rsp_empty) fall_sb.check_word(rsp_word);
      end
   end

   // result side: pop high, with random stall bursts while idling is on
   initial begin
      rsp_pop = 0;
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_pop <= 1;
            @(posedge clock);
         end
      end
   end

   // push one sample word; push stays high so back-to-back words need no gap
   task push_sample(logic [9:0] x, logic [9:0] y, logic [9:0] z, logic [31:0] now);
      req_type w;
      w.accel_x = x;
      w.accel_y = y;
      w.accel_z = z;
      w.now_ms = now;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push <= 1;
      req_word <= w;
      do @(posedge clock); while (req_full);
      sent++;
   endtask

   // stop pushing and let every expected word drain, plus the back unit latency
   task drain_block();
      req_push <= 0;
      while (fall_sb.expected_words.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   // valid stays high across a burst of writes; the caller drops it
   task write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      fall_sb.write_reg(idx, val);
      reg_val[idx] = val;
   endtask

   // rest level on an axis in raw counts
   function automatic logic [9:0] rest_raw(int idx);
      return 10'(reg_val[idx] >> 4);
   endfunction

   // one fall attempt: wait out the cooldown, a burst of impacts, then motion
   task fall_attempt(int budget);
      int mode, n, dt, step;
      logic [9:0] rx, ry, rz, x, y;
      rx = rest_raw(CSR_BASE_X);
      ry = rest_raw(CSR_BASE_Y);
      rz = rest_raw(CSR_BASE_Z);
      // sometimes too early so the cooldown gets hit
      if ($urandom_range(0, 4) == 0) t_ms += $urandom_range(0, 3000);
      else t_ms += reg_val[CSR_COOLDOWN] + $urandom_range(1, 3000);
      // a rest sample first lets the re-arm happen on its own
      push_sample(rx, ry, rz, t_ms);
      repeat (IMPACT_N + $urandom_range(0, 1)) begin
         t_ms += $urandom_range(0, 40);
         push_sample(rx > 511 ? 10'd0 : 10'd1023, ry > 511 ? 10'd0 : 10'd1023,
                     10'($urandom_range(0, 399)), t_ms);
      end
      mode = $urandom_range(0, 3);
      n = $urandom_range(30, 90);
      for (step = 0; step < n && sent < budget; step++) begin
         dt = $urandom_range(100, 700);
         t_ms += dt;
         if ($urandom_range(0, 19) == 0) begin
            // stray word anywhere on the timeline
            push_sample(10'($urandom), 10'($urandom), 10'($urandom), $urandom);
         end else begin
            case (mode)
               0: begin
                  x = rx + 10'($urandom_range(0, 1));
                  push_sample(x, ry, rz, t_ms);
               end
               1: push_sample(10'($urandom), 10'($urandom), 10'($urandom), t_ms);
               2: begin
                  x = rx + 10'($urandom_range(0, 1) ? $urandom_range(15, 40) : 0);
                  push_sample(x, ry, rz, t_ms);
               end
               default: begin
                  y = (step < n / 2) ? ry : 10'($urandom);
                  push_sample(rx, y, rz, t_ms);
               end
            endcase
         end
      end
   endtask

   task load_settings(int kind);
      bit [15:0] v[8];
      int i;
      case (kind)
         0: v = '{16'd8184, 16'd8184, 16'd8184, 16'd2080, 16'd112, 16'd1280,
                  16'd10000, 16'd6000};
         // impacts everywhere, always still, instant confirm, no cooldown
         1: v = '{16'd0, 16'd16368, 16'd8184, 16'd0, 16'd28352, 16'd28352,
                  16'd0, 16'd0};
         // impacts never counted, longest times
         2: v = '{16'd16368, 16'd0, 16'd16368, 16'd28352, 16'd0, 16'd0,
                  16'd65535, 16'd65535};
         default: begin
            for (i = 0; i < 3; i++) v[i] = 16'($urandom_range(7000, 9500));
            v[3] = 16'($urandom_range(500, 4000));
            v[4] = 16'($urandom_range(30, 400));
            v[5] = 16'($urandom_range(400, 3000));
            v[6] = 16'($urandom_range(0, 20000));
            v[7] = 16'($urandom_range(0, 8000));
         end
      endcase
      for (i = 0; i < 8; i++) write_csr(3'(i), v[i]);
      csr_valid <= 0;
   endtask

   initial begin
      int kinds[6];
      int ph, budget;
      fall_sb = new();
      kinds = '{0, 3, 1, 3, 2, 3};
      reg_val = '{16'd8184, 16'd8184, 16'd8184, 16'd2080, 16'd112, 16'd1280,
                  16'd10000, 16'd6000};
      reset = 1;
      req_push = 0;
      req_word = '0;
      csr_valid = 0;
      csr_index = CSR_BASE_X;
      csr_data = '0;
      idle_on = 0;
      sent = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, start-up cooldown, possible fall, a still window,
      // an impact that cancels, impacts in the cooldown, then re-arm on still samples
      push_sample(10'd0, 10'd0, 10'd0, 32'd0);
      push_sample(10'd1023, 10'd1023, 10'd1023, 32'd50);
      push_sample(10'd1023, 10'd0, 10'd0, 32'd100);     // ignored: start-up cooldown
      push_sample(10'd1023, 10'd0, 10'd0, 32'd110);
      push_sample(10'd1023, 10'd0, 10'd0, 32'd7000);
      push_sample(10'd1023, 10'd0, 10'd0, 32'd7010);
      push_sample(10'd1023, 10'd0, 10'd0, 32'd7020);    // possible fall
      for (int i = 0; i < 6; i++)                        // swings of equal magnitude: still
         push_sample(i % 2 ? 10'd1023 : 10'd0, 10'd511, 10'd511, 32'(10100 + i * 1000));
      push_sample(10'd1023, 10'd0, 10'd0, 32'd21150);   // impact: cancel, cooldown starts
      push_sample(10'd1023, 10'd0, 10'd0, 32'd21160);
      push_sample(10'd1023, 10'd0, 10'd0, 32'd21170);   // in the cooldown: no possible fall
      for (int i = 0; i < 8; i++)                        // lying still: re-arm once the cooldown ends
         push_sample(10'd511, 10'd511, 10'd511, 32'(24500 + i * 3000));
      push_sample(10'd511, 10'd511, 10'd511, 32'hFFFF_FFFF);
      drain_block();

      // random phases, one register setting each
      t_ms = 32'd60000;
      idle_on = 1;
      ph = 0;
      while (sent < TOTAL_WORDS) begin
         load_settings(kinds[ph % 6]);
         if ($urandom_range(0, 2) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 40000);
         budget = sent + 240;
         if (budget > TOTAL_WORDS) budget = TOTAL_WORDS;
         while (sent < budget) begin
            if (sent > TOTAL_WORDS - 220) idle_on = 0;
            fall_attempt(budget);
         end
         drain_block();
         ph++;
      end

      $display("%0d samples sent over %0d register settings, %0d result words checked",
               sent, ph + 1, fall_sb.words_out);
      $display("events: possible %0d, cancel %0d, confirm %0d, timeout %0d, re-arm %0d",
               fall_sb.event_seen[EV_POSSIBLE], fall_sb.event_seen[EV_CANCEL],
               fall_sb.event_seen[EV_CONFIRM], fall_sb.event_seen[EV_TIMEOUT],
               fall_sb.event_seen[EV_REARM]);
      if (fall_sb.mismatches == 0 && fall_sb.expected_words.size() == 0) begin
         $display("tb_accel_fall_detector_top: PASS");
      end else begin
         $display("%0d mismatches, %0d words missing", fall_sb.mismatches,
                  fall_sb.expected_words.size());
         $display("tb_accel_fall_detector_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("timeout with %0d words outstanding", fall_sb.expected_words.size());
      $display("tb_accel_fall_detector_top: FAIL");
      $finish;
   end
endmodule

>>> sim.f
+incdir+design
design/afd_pkg.sv
design/afd_front.sv
design/afd_back.sv
design/afd_queue.sv
design/accel_fall_detector_top.sv
tb/tb_accel_fall_detector_top.sv
